// ===== src/toroidal_min_distance_point_filter_core_macros.svh =====
// Assertion macros for the toroidal minimum-distance point filter.
// Expects clk and arst_n in the scope of each use.
`ifndef TOROIDAL_MIN_DISTANCE_POINT_FILTER_CORE_MACROS_SVH
`define TOROIDAL_MIN_DISTANCE_POINT_FILTER_CORE_MACROS_SVH

// check an implication on every clock edge outside reset
`define TMDPF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a condition on the edge after the antecedent
`define TMDPF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tmdpf_pkg.sv =====
// Shared constants and types of the toroidal minimum-distance point filter.
// No dependencies.
`default_nettype none
package tmdpf_pkg;

	localparam int MAX_POINTS = 64;
	localparam int AW         = $clog2(MAX_POINTS);
	localparam int CW         = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int COL_W      = 32;
	localparam int DIST_W     = 32;
	localparam int IDX_W      = 6;
	localparam int SQ_W       = 31;
	localparam int PT_W       = 2 * COORD_W + COL_W;
	localparam int OUT_DW     = 72;

	typedef struct packed {
		logic [COL_W-1:0]   colour;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic vld;
		logic hit;
	} dist_res_t;

endpackage
`default_nettype wire

// ===== src/tmdpf_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module tmdpf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/tmdpf_dist.sv =====
// Wrap-around squared distance and threshold compare; the squares are registered.
// Depends on tmdpf_pkg.
`default_nettype none
module tmdpf_dist (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_vld,
	input  wire logic                            flush,
	input  wire logic [tmdpf_pkg::COORD_W-1:0]   ref_x,
	input  wire logic [tmdpf_pkg::COORD_W-1:0]   ref_y,
	input  wire logic [tmdpf_pkg::COORD_W-1:0]   cmp_x,
	input  wire logic [tmdpf_pkg::COORD_W-1:0]   cmp_y,
	input  wire logic [tmdpf_pkg::DIST_W-1:0]    min_dist_sq,
	output tmdpf_pkg::dist_res_t                 res
);
	import tmdpf_pkg::*;

	localparam int DW = COORD_W + 1;

	logic [COORD_W-1:0] dx_raw, dy_raw;
	logic [DW-1:0]      dx_alt, dy_alt, dx, dy;
	logic [2*DW-1:0]    px, py;
	logic [SQ_W-1:0]    px_s2, py_s2;
	logic               vld_s2;
	logic [DIST_W-1:0]  sq;

	always_comb begin
		dx_raw = cmp_x - ref_x;
		dy_raw = cmp_y - ref_y;
		dx_alt = (DW'(1) << COORD_W) - DW'(dx_raw);
		dy_alt = (DW'(1) << COORD_W) - DW'(dy_raw);
		dx     = (DW'(dx_raw) < dx_alt) ? DW'(dx_raw) : dx_alt;
		dy     = (DW'(dy_raw) < dy_alt) ? DW'(dy_raw) : dy_alt;
		px     = dx * dx;
		py     = dy * dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			px_s2  <= '0;
			py_s2  <= '0;
		end else begin
			vld_s2 <= in_vld & ~flush;
			px_s2  <= px[SQ_W-1:0];
			py_s2  <= py[SQ_W-1:0];
		end
	end

	assign sq      = DIST_W'(px_s2) + DIST_W'(py_s2);
	assign res.vld = vld_s2;
	assign res.hit = vld_s2 && (sq < min_dist_sq);

endmodule
`default_nettype wire

// ===== src/toroidal_min_distance_point_filter_core.sv =====
// Top level of the toroidal minimum-distance point filter: control sequencer.
// Depends on tmdpf_pkg, tmdpf_ram, tmdpf_dist and the assertion macro header.
//
// Usage:
//   s_axis carries points (x, y, colour), one per cycle while loading; the
//   item with tlast closes the set. Up to 64 points are stored, further ones
//   are dropped and reported through m_axis_tuser on every result of the run.
//   After tlast the set is thinned in place: each point i is compared with
//   points 0..i-1 through the single read port of the point memory, one
//   compare per cycle until a rejection; a rejected point is overwritten by
//   the last point of the set and its slot is tested again. Survivors then
//   leave on m_axis, tlast on the final one; the next survivor is read only
//   once the previous read has reached the output register. s_axis is not
//   ready while thinning and emitting; it is ready again as soon as the last
//   result is read from memory, even if that result still waits in the
//   output register. A stalled m_axis holds its item and the emit sequence
//   waits. cfg writes min_dist_sq at any time and are always accepted; write
//   only while idle. Reset clears the point count, the overflow flag and
//   min_dist_sq; the point memory needs no clearing.
`default_nettype none
`include "toroidal_min_distance_point_filter_core_macros.svh"
module toroidal_min_distance_point_filter_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// pos_x [15:0], pos_y [31:16], colour [63:32]
	input  wire logic [tmdpf_pkg::PT_W-1:0]     s_axis_tdata,
	input  wire logic                           s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// out_x [15:0], out_y [31:16], out_colour [63:32], out_index [69:64], zero [71:70]
	output logic      [tmdpf_pkg::OUT_DW-1:0]   m_axis_tdata,
	output logic                                m_axis_tlast,
	// overflow [0]
	output logic                                m_axis_tuser,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tmdpf_pkg::DIST_W-1:0]   cfg_data
);
	import tmdpf_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_CAPT,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      j_q;
	logic [AW-1:0]      k_q;
	logic [AW-1:0]      fetch_q;
	logic               copy_q;
	logic               v_s1;
	point_t             cur_q;
	logic [DIST_W-1:0]  min_q;
	logic               pend_q;
	logic               pend_last_q;
	logic               pend_ovf_q;
	logic [AW-1:0]      pend_idx_q;
	logic               m_vld_q;
	logic [OUT_DW-1:0]  m_data_q;
	logic               m_last_q;
	logic               m_user_q;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	point_t             ram_wdata, ram_rdata, in_pt;
	dist_res_t          dres;

	logic               load_acc, load_wr, scan_issue, scan_done, emit_issue;
	logic [CW-1:0]      n_load, n_dec, i_next, k_next;

	assign in_pt         = point_t'(s_axis_tdata);
	assign s_axis_tready = (state_q == ST_LOAD);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

	always_comb begin
		load_acc   = s_axis_tvalid && (state_q == ST_LOAD);
		load_wr    = load_acc && (count_q < CW'(MAX_POINTS));
		n_load     = load_wr ? count_q + CW'(1) : count_q;
		n_dec      = count_q - CW'(1);
		i_next     = CW'(i_q) + CW'(1);
		k_next     = CW'(k_q) + CW'(1);
		scan_issue = (state_q == ST_SCAN) && (j_q != i_q) && !dres.hit;
		scan_done  = (state_q == ST_SCAN) && (j_q == i_q) && !v_s1 && !dres.vld;
		emit_issue = (state_q == ST_EMIT) && !pend_q && (!m_vld_q || m_axis_tready);

		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = in_pt;
		if (load_wr) begin
			ram_we = 1'b1;
		end else if (state_q == ST_CAPT && copy_q) begin
			ram_we    = 1'b1;
			ram_waddr = i_q;
			ram_wdata = ram_rdata;
		end

		ram_re    = 1'b0;
		ram_raddr = fetch_q;
		unique case (state_q)
			ST_FETCH: begin
				ram_re = 1'b1;
			end
			ST_SCAN: begin
				ram_re    = scan_issue;
				ram_raddr = j_q;
			end
			ST_EMIT: begin
				ram_re    = emit_issue;
				ram_raddr = k_q;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	tmdpf_ram #(
		.WIDTH(PT_W),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tmdpf_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (v_s1),
		.flush       (dres.hit),
		.ref_x       (cur_q.x),
		.ref_y       (cur_q.y),
		.cmp_x       (ram_rdata.x),
		.cmp_y       (ram_rdata.y),
		.min_dist_sq (min_q),
		.res         (dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			fetch_q     <= '0;
			copy_q      <= 1'b0;
			v_s1        <= 1'b0;
			cur_q       <= '0;
			min_q       <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			pend_ovf_q  <= 1'b0;
			pend_idx_q  <= '0;
			m_vld_q     <= 1'b0;
			m_data_q    <= '0;
			m_last_q    <= 1'b0;
			m_user_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				min_q <= cfg_data;
			end

			v_s1 <= scan_issue;

			if (pend_q) begin
				m_vld_q  <= 1'b1;
				m_data_q <= {(OUT_DW - PT_W - IDX_W)'(0), IDX_W'(pend_idx_q), ram_rdata};
				m_last_q <= pend_last_q;
				m_user_q <= pend_ovf_q;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
			pend_q <= emit_issue;

			unique case (state_q)
				ST_LOAD: begin
					if (load_acc) begin
						count_q <= n_load;
						if (!load_wr) begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							i_q     <= AW'(1);
							fetch_q <= AW'(1);
							copy_q  <= 1'b0;
							k_q     <= '0;
							state_q <= (n_load > CW'(1)) ? ST_FETCH : ST_EMIT;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_CAPT;
				end
				ST_CAPT: begin
					cur_q   <= ram_rdata;
					j_q     <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						j_q <= j_q + AW'(1);
					end
					if (dres.hit) begin
						count_q <= n_dec;
						fetch_q <= n_dec[AW-1:0];
						copy_q  <= 1'b1;
						state_q <= (CW'(i_q) < n_dec) ? ST_FETCH : ST_EMIT;
					end else if (scan_done) begin
						i_q     <= i_next[AW-1:0];
						fetch_q <= i_next[AW-1:0];
						copy_q  <= 1'b0;
						state_q <= (i_next < count_q) ? ST_FETCH : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						pend_idx_q  <= k_q;
						pend_last_q <= (k_next == count_q);
						pend_ovf_q  <= ovf_q;
						k_q         <= k_next[AW-1:0];
						if (k_next == count_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	`TMDPF_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_POINTS), "point count beyond capacity")
	`TMDPF_ASSERT_IMP(a_scan_range, state_q == ST_SCAN, j_q <= i_q && CW'(i_q) < count_q, "scan index out of range")
	`TMDPF_ASSERT_IMP(a_hit_in_scan, dres.vld, state_q == ST_SCAN, "distance result outside scan")
	`TMDPF_ASSERT_NXT(a_emit_fill, pend_q, m_vld_q, "read point not placed in output register")

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for toroidal_min_distance_point_filter_core: loads point sets,
// predicts the thinned survivors and compares each emitted item. Depends on tmdpf_pkg.
module tb;
	import tmdpf_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 12;
	localparam int RAND_ITEMS  = 280;

	typedef struct {
		point_t         pt;
		logic [IDX_W-1:0] idx;
		logic           fin;
		logic           ovf;
	} survivor_t;

	class survivor_board;
		point_t          bank[MAX_POINTS];
		int unsigned     fill;
		bit              dropped;
		logic [DIST_W-1:0] spacing;
		survivor_t       survivors_due[$];
		int              errors;
		int              shown;

		function new();
			fill = 0;
			dropped = 0;
			spacing = '0;
			errors = 0;
			shown = 0;
		endfunction

		function void report(string msg);
			if (shown < 40)
				$display("tb: mismatch at %0t: %s", $realtime, msg);
			shown++;
			errors++;
		endfunction

		function void set_spacing(logic [DIST_W-1:0] v);
			spacing = v;
		endfunction

		function int pending();
			return survivors_due.size();
		endfunction

		function logic [COORD_W:0] ring_gap(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
			logic [COORD_W-1:0] d;
			logic [COORD_W:0]   e;
			d = a - b;
			e = 17'h10000 - d;
			return (d < e) ? {1'b0, d} : e;
		endfunction

		function bit too_close(point_t a, point_t b);
			logic [COORD_W:0]  dx;
			logic [COORD_W:0]  dy;
			logic [DIST_W-1:0] sq;
			dx = ring_gap(a.x, b.x);
			dy = ring_gap(a.y, b.y);
			sq = dx * dx + dy * dy;
			return sq < spacing;
		endfunction

		function void prune_close_points();
			int unsigned n;
			int unsigned i;
			bit hit;
			n = fill;
			i = 1;
			while (i < n) begin
				hit = 0;
				for (int unsigned j = 0; j < i; j++) begin
					if (too_close(bank[i], bank[j])) begin
						hit = 1;
						break;
					end
				end
				if (hit) begin
					n--;
					bank[i] = bank[n];
				end else begin
					i++;
				end
			end
			fill = n;
		endfunction

		function void note_point(point_t p, bit last);
			survivor_t s;
			if (fill < MAX_POINTS) begin
				bank[fill] = p;
				fill++;
			end else begin
				dropped = 1;
			end
			if (!last)
				return;
			prune_close_points();
			for (int unsigned k = 0; k < fill; k++) begin
				s.pt  = bank[k];
				s.idx = k[IDX_W-1:0];
				s.fin = (k + 1 == fill);
				s.ovf = dropped;
				survivors_due.push_back(s);
			end
			fill = 0;
			dropped = 0;
		endfunction

		function void check_survivor(logic [OUT_DW-1:0] data, logic fin, logic ovf);
			survivor_t s;
			if (survivors_due.size() == 0) begin
				report($sformatf("unexpected item data=%h last=%b user=%b", data, fin, ovf));
				return;
			end
			s = survivors_due.pop_front();
			if (data[15:0] !== s.pt.x || data[31:16] !== s.pt.y || data[63:32] !== s.pt.colour
					|| data[69:64] !== s.idx || data[71:70] !== 2'b00
					|| fin !== s.fin || ovf !== s.ovf)
				report($sformatf("got x=%h y=%h c=%h i=%0d z=%b l=%b o=%b, want x=%h y=%h c=%h i=%0d l=%b o=%b",
					data[15:0], data[31:16], data[63:32], data[69:64], data[71:70], fin, ovf,
					s.pt.x, s.pt.y, s.pt.colour, s.idx, s.fin, s.ovf));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [PT_W-1:0]   s_axis_tdata = '0;
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_DW-1:0] m_axis_tdata;
	logic              m_axis_tlast;
	logic              m_axis_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [DIST_W-1:0] cfg_data = '0;

	survivor_board sb = new();
	int  points_sent = 0;
	int  cycles = 0;
	int  sink_hold = 0;
	bit  src_calm = 0;
	bit  snk_calm = 0;

	toroidal_min_distance_point_filter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_survivor(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_axis_tready <= 1'b1;
			sink_hold = pick_gap(snk_calm);
		end
	end

	task automatic send_point(logic [15:0] x, logic [15:0] y, logic [31:0] colour, bit last);
		int g;
		point_t p;
		g = pick_gap(src_calm);
		p.x = x;
		p.y = y;
		p.colour = colour;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= p;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_point(p, last);
		points_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_spacing(logic [31:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_spacing(v);
	endtask

	task automatic random_set(int n);
		bit   clustered;
		int   spread;
		logic [15:0] cx;
		logic [15:0] cy;
		clustered = $urandom_range(0, 1);
		spread = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 2000);
		cx = $urandom_range(0, 3) == 0 ? 16'hFFF8 : 16'($urandom);
		cy = $urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom);
		for (int k = 0; k < n; k++) begin
			if (clustered)
				send_point(cx + 16'($urandom_range(0, spread)), cy + 16'($urandom_range(0, spread)),
					$urandom, k == n - 1);
			else
				send_point(16'($urandom), 16'($urandom), $urandom, k == n - 1);
		end
	endtask

	function automatic logic [31:0] pick_spacing();
		case ($urandom_range(0, 6))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			3: return $urandom_range(1, 64);
			4: return $urandom_range(1, 32'h0010_0000);
			5: return 32'h8000_0000;
			default: return $urandom_range(1, 32'h0400_0000);
		endcase
	endfunction

	initial begin
		int set_no;
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all points kept at the reset spacing
		send_point(16'h0000, 16'h0000, 32'h0000_0000, 1);
		send_point(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send_point(16'h8000, 16'h7FFF, 32'hA5A5_A5A5, 0);
		send_point(16'h0000, 16'h0000, 32'h5A5A_5A5A, 1);

		// widest spacing keeps only the first point
		write_spacing(32'hFFFF_FFFF);
		send_point(16'h1234, 16'h5678, 32'h0102_0304, 0);
		send_point(16'hFFFF, 16'h0000, 32'hFFFF_0000, 0);
		send_point(16'h0000, 16'hFFFF, 32'h0000_FFFF, 1);

		// wrap-around neighbors: distance exactly at the limit survives
		write_spacing(32'd2);
		send_point(16'h0000, 16'h0000, 32'h1111_1111, 0);
		send_point(16'hFFFF, 16'hFFFF, 32'h2222_2222, 0);
		send_point(16'h0000, 16'h0001, 32'h3333_3333, 0);
		send_point(16'hFFFF, 16'h0000, 32'h4444_4444, 0);
		send_point(16'h8000, 16'h8000, 32'h5555_5555, 1);

		// farthest pair on the torus
		write_spacing(32'h8000_0000);
		send_point(16'h0000, 16'h0000, 32'hDEAD_BEEF, 0);
		send_point(16'h8000, 16'h8000, 32'hCAFE_F00D, 1);
		write_spacing(32'h8000_0001);
		send_point(16'h0000, 16'h0000, 32'h0F0F_0F0F, 0);
		send_point(16'h8000, 16'h8000, 32'hF0F0_F0F0, 1);

		set_no = 0;
		while (points_sent < 16 + RAND_ITEMS) begin
			src_calm = ($urandom_range(0, 4) == 0);
			snk_calm = ($urandom_range(0, 4) == 0);
			if (set_no == 1 || set_no == 3) begin
				write_spacing(32'h0000_0000);
				n = (set_no == 1) ? MAX_POINTS : $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
			end else begin
				if ($urandom_range(0, 2) == 0)
					write_spacing(pick_spacing());
				n = ($urandom_range(0, 11) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
			end
			random_set(n);
			set_no++;
		end

		wait_drained();
		if (sb.pending() != 0)
			sb.report("expected items left over");
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
